[hw/rtl/rmfpc_pkg.sv]
// Shared types and constants for the page-column frame store.
// No dependencies; imported by the front, back and top-level modules of the block.
`default_nettype none

package rmfpc_pkg;

  // Rows gathered by one page read
  localparam int ROWS_PER_PAGE = 8;

  // Width used to form byte addresses before truncation to the store depth
  localparam int ADDR_CALC_W = 13;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Operation carried from front to back
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_ZERO  = 2'd2
  } op_t;

  // Command part of one queue entry; the address travels beside it
  typedef struct packed {
    op_t        op;
    logic [7:0] data;  // write: pixel byte; read: pixel offset in bits [2:0]
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/rmfpc_front.sv]
// Front part: classifies each input item, range-checks it and forms its address.
// Depends on rmfpc_pkg.
`default_nettype none

module rmfpc_front #(
  parameter int BYTES_PER_ROW = 16,
  parameter int PAGE_COUNT    = 8,
  parameter int AW            = 10
) (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 command,
  input  logic [5:0]           pixel_row,
  input  logic [3:0]           byte_column,
  input  logic [7:0]           pixel_byte,
  input  logic [2:0]           page,
  input  logic [6:0]           column,
  input  logic                 q_full,
  output logic                 push,
  output rmfpc_pkg::cmd_t      push_cmd,
  output logic [AW-1:0]        push_addr
);
  import rmfpc_pkg::*;

  localparam int ROW_COUNT = PAGE_COUNT * ROWS_PER_PAGE;

  logic                   wr_in_frame;
  logic                   rd_in_frame;
  logic [3:0]             rd_bcol;
  logic [ADDR_CALC_W-1:0] wr_full;
  logic [ADDR_CALC_W-1:0] rd_full;

  assign rd_bcol     = column[6:3];
  assign wr_in_frame = (32'(pixel_row) < 32'(ROW_COUNT))
                    && (32'(byte_column) < 32'(BYTES_PER_ROW));
  assign rd_in_frame = (32'(page) < 32'(PAGE_COUNT))
                    && (32'(rd_bcol) < 32'(BYTES_PER_ROW));

  assign wr_full = ADDR_CALC_W'(pixel_row) * ADDR_CALC_W'(BYTES_PER_ROW)
                 + ADDR_CALC_W'(byte_column);
  assign rd_full = ADDR_CALC_W'(page) * ADDR_CALC_W'(ROWS_PER_PAGE * BYTES_PER_ROW)
                 + ADDR_CALC_W'(rd_bcol);

  assign in_ready = !q_full;

  always_comb begin
    push_cmd  = '{op: OP_WRITE, data: pixel_byte};
    push_addr = wr_full[AW-1:0];
    // drop writes that fall outside the frame
    push      = in_valid && !q_full && wr_in_frame;
    if (command) begin
      push_cmd  = '{op: (rd_in_frame ? OP_READ : OP_ZERO), data: {5'd0, column[2:0]}};
      push_addr = rd_full[AW-1:0];
      push      = in_valid && !q_full;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rmfpc_queue.sv]
// Small first-word-fall-through queue between front and back.
// No package dependencies.
`default_nettype none

module rmfpc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rmfpc_back.sv]
// Back part: frame store memory and the sequencer that gathers one page column.
// Depends on rmfpc_pkg.
`default_nettype none

module rmfpc_back #(
  parameter int BYTES_PER_ROW = 16,
  parameter int PAGE_COUNT    = 8,
  parameter int AW            = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  rmfpc_pkg::cmd_t q_cmd,
  input  logic [AW-1:0]   q_addr,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_data
);
  import rmfpc_pkg::*;

  localparam int MEM_DEPTH = PAGE_COUNT * ROWS_PER_PAGE * BYTES_PER_ROW;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_GATHER = 3'b010,
    ST_DONE   = 3'b100
  } state_t;

  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    rd_data;
  state_t        state;
  logic [AW-1:0] addr;
  logic [2:0]    sel;
  logic [3:0]    cnt;
  logic          rd_pending;
  logic [7:0]    acc;
  logic [7:0]    acc_next;
  logic          issue;
  logic          mem_wr;
  logic          out_free;

  assign out_free = !out_valid || out_ready;
  assign pop      = (state == ST_IDLE) && q_valid;
  assign mem_wr   = pop && (q_cmd.op == OP_WRITE);
  assign issue    = (state == ST_GATHER) && !cnt[3];
  // bit j of the column byte enters at the top and shifts down
  assign acc_next = {rd_data[~sel], acc[7:1]};

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[q_addr] <= q_cmd.data;
    end
    if (issue) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      addr <= addr + AW'(BYTES_PER_ROW);
    end else if (pop) begin
      addr <= q_addr;
    end
    if (pop) begin
      sel <= q_cmd.data[2:0];
    end
    if (pop && (q_cmd.op == OP_ZERO)) begin
      acc <= '0;
    end else if (rd_pending) begin
      acc <= acc_next;
    end
    if ((state == ST_DONE) && out_free) begin
      out_data <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pending <= issue;
      // hold a stalled beat, load a finished one
      out_valid  <= (out_valid && !out_ready) || ((state == ST_DONE) && out_free);
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (pop) begin
            case (q_cmd.op)
              OP_READ:  state <= ST_GATHER;
              OP_ZERO:  state <= ST_DONE;
              default:  state <= ST_IDLE;
            endcase
          end
        end
        ST_GATHER: begin
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          if (rd_pending && cnt[3]) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/row_major_frame_to_page_columns_unit.sv]
// Top level of the row-major frame store with page-column readout.
// Depends on rmfpc_pkg, rmfpc_front, rmfpc_queue and rmfpc_back.
//
//   channel  | dir | handshake                    | payload
//   ---------+-----+------------------------------+-------------------------------
//   s_axis   | in  | s_axis_tvalid/s_axis_tready  | tuser: command; tdata: fields
//   m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: column_byte
//
// A write is stored in the frame store as it leaves the queue.
// A page read leaves the queue, makes eight single-port reads of the frame store
// (one row byte each) through its registered read port, and then moves the
// gathered byte into the output register.
// A read outside the frame skips the memory and returns zero.
// rst is synchronous; it empties the queue and the output register but not
// the frame store, whose contents are undefined until written.
// A stalled output holds the back part; the queue keeps taking items until full.
`default_nettype none

module row_major_frame_to_page_columns_unit #(
  parameter int BYTES_PER_ROW = 16,
  parameter int PAGE_COUNT    = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] pixel_row, [9:6] byte_column, [17:10] pixel_byte, [20:18] page,
  // [27:21] column, [31:28] zero
  input  logic [31:0] s_axis_tdata,
  // [0] command
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] column_byte
  output logic [7:0]  m_axis_tdata
);
  import rmfpc_pkg::*;

  localparam int AW = $clog2(PAGE_COUNT * ROWS_PER_PAGE * BYTES_PER_ROW);
  localparam int QW = AW + $bits(cmd_t);

  logic          q_full;
  logic          push;
  cmd_t          push_cmd;
  logic [AW-1:0] push_addr;
  logic          pop;
  logic          q_valid;
  logic [QW-1:0] q_head;
  cmd_t          q_cmd;
  logic [AW-1:0] q_addr;

  // Classify and address each item as it arrives
  rmfpc_front #(
    .BYTES_PER_ROW (BYTES_PER_ROW),
    .PAGE_COUNT    (PAGE_COUNT),
    .AW            (AW)
  ) u_front (
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .command     (s_axis_tuser),
    .pixel_row   (s_axis_tdata[5:0]),
    .byte_column (s_axis_tdata[9:6]),
    .pixel_byte  (s_axis_tdata[17:10]),
    .page        (s_axis_tdata[20:18]),
    .column      (s_axis_tdata[27:21]),
    .q_full      (q_full),
    .push        (push),
    .push_cmd    (push_cmd),
    .push_addr   (push_addr)
  );

  // Decouple front and back so each may stall on its own
  rmfpc_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_addr, push_cmd}),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  assign q_addr = q_head[QW-1 -: AW];
  assign q_cmd  = q_head[$bits(cmd_t)-1:0];

  // Store writes and gather page columns in arrival order
  rmfpc_back #(
    .BYTES_PER_ROW (BYTES_PER_ROW),
    .PAGE_COUNT    (PAGE_COUNT),
    .AW            (AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_addr    (q_addr),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire

[hw/rtl/rmfpc_checker.sv]
// Port-level checks for the page-column frame store, bound to the top level.
// No package dependencies.
`default_nettype none

module rmfpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  logic       rd_beat;
  logic       res_beat;
  logic [3:0] owed;

  assign rd_beat  = s_axis_tvalid && s_axis_tready && s_axis_tuser;
  assign res_beat = m_axis_tvalid && m_axis_tready;

  // Count read beats whose column byte has not yet been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else begin
      owed <= owed + 4'(rd_beat) - 4'(res_beat);
    end
  end

  // A stalled result beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its data
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered straight after reset");

  // Every result beat answers a read beat still owed
  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (owed != '0))
    else $error("result offered with no read outstanding");

endmodule

bind row_major_frame_to_page_columns_unit rmfpc_checker u_rmfpc_checker (.*);

`default_nettype wire
